// File: design/fpalu_pkg.sv
// Package for the fixed-point ALU: commands, beat types and shared constants.
package fpalu_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FIFO_DEPTH     = 2;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } out_t;

  // Classified operation handed from the front to the back through the queue.
  typedef struct packed {
    op_e                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lt;
    logic               eq;
    logic               b_zero;
    logic               div_neg;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
  } cls_t;

endpackage

// File: design/fixed_point_alu_top.sv
// Top level of the fixed-point ALU: front end, operation queue and execution pipeline.
//
//   channel   signals                             beat
//   input     in_valid_i, in_ready_o, in_data_i    command and two operands
//   output    out_valid_o, out_ready_i, out_data_o result, compare flag, zero-divide flag
//
// One beat enters per cycle while the queue has room; each operation passes the queue,
// execution stages and output register; the divider resolves one quotient bit per stage.
// All operations share that pipeline, so results leave in order.
// Reset clears the queue and the pipeline valid bits; no clearing pass is needed.
// A stalled output freezes the pipeline while the queue still takes beats until full.
module fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS  = fpalu_pkg::FRAC_BITS_DEF,
  parameter int unsigned DATA_WIDTH = fpalu_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fpalu_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fpalu_pkg::out_t  out_data_o
);
  import fpalu_pkg::*;

  cls_t front_cls, queue_cls;
  logic push, full, pop, queue_valid;

  fpalu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cls_o      (front_cls),
    .full_i     (full)
  );

  fpalu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cls),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .data_o  (queue_cls)
  );

  fpalu_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .cls_i       (queue_cls),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/fpalu_front.sv
// Front end of the fixed-point ALU: accepts beats and classifies operations.
module fpalu_front #(
  parameter int unsigned DATA_WIDTH = fpalu_pkg::DATA_WIDTH_DEF
) (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fpalu_pkg::in_t   in_data_i,
  output logic             push_o,
  output fpalu_pkg::cls_t  cls_o,
  input  logic             full_i
);
  import fpalu_pkg::*;

  logic signed [DATA_WIDTH-1:0] aw, bw;
  logic signed [31:0]           a32, b32;

  assign aw  = in_data_i.operand_a[DATA_WIDTH-1:0];
  assign bw  = in_data_i.operand_b[DATA_WIDTH-1:0];
  assign a32 = 32'(aw);
  assign b32 = 32'(bw);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cls_o.op      = op_e'(in_data_i.command);
    cls_o.a       = a32;
    cls_o.b       = b32;
    cls_o.lt      = a32 < b32;
    cls_o.eq      = a32 == b32;
    cls_o.b_zero  = b32 == 32'sd0;
    cls_o.div_neg = a32[31] ^ b32[31];
    cls_o.abs_a   = a32[31] ? 32'(-a32) : 32'(a32);
    cls_o.abs_b   = b32[31] ? 32'(-b32) : 32'(b32);
  end

endmodule

// File: design/fpalu_fifo.sv
// Short queue of classified operations between the front and the back.
module fpalu_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fpalu_pkg::cls_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output fpalu_pkg::cls_t  data_o
);
  import fpalu_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  cls_t          mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_pop;

  assign full_o  = cnt_q == (PW+1)'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? ((wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: design/fpalu_back.sv
// Back end of the fixed-point ALU: execution pipeline with a bit-per-stage divider.
module fpalu_back #(
  parameter int unsigned DATA_WIDTH = fpalu_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = fpalu_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  fpalu_pkg::cls_t  cls_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fpalu_pkg::out_t  out_data_o
);
  import fpalu_pkg::*;

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned N = W + F;

  typedef struct packed {
    logic           is_mul;
    logic           is_div;
    logic           dz;
    logic           neg;
    logic           cmp;
    logic [W-1:0]   res;
    logic [2*W-1:0] prod;
    logic [W:0]     rem;
    logic [N-1:0]   dvd;
    logic [W-1:0]   dvs;
  } stage_t;

  stage_t stg_q [N+1];
  stage_t stg_d [N+1];
  stage_t s0_d;
  logic [N:0] vld_q, vld_d;
  logic       en;
  out_t       out_q, out_d;
  logic       out_vld_q;

  logic signed [W-1:0]   aw, bw, tsum;
  logic [2*W-1:0]        mbias;
  logic [W:0]            trial;
  logic [W-1:0]          q_w;

  assign en          = !out_vld_q || out_ready_i;
  assign pop_o       = en && valid_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign aw    = cls_i.a[W-1:0];
  assign bw    = cls_i.b[W-1:0];
  assign tsum  = aw + (aw[W-1] ? W'((1 << F) - 1) : W'(0));
  assign mbias = {{(2*W-F){1'b0}}, {F{1'b1}}};

  always_comb begin
    s0_d        = '0;
    s0_d.is_mul = cls_i.op == OP_MUL;
    s0_d.is_div = cls_i.op == OP_DIV;
    s0_d.dz     = (cls_i.op == OP_DIV) && cls_i.b_zero;
    s0_d.neg    = cls_i.div_neg;
    s0_d.prod   = (2*W)'(aw * bw);
    s0_d.rem    = '0;
    s0_d.dvd    = {cls_i.abs_a[W-1:0], {F{1'b0}}};
    s0_d.dvs    = cls_i.abs_b[W-1:0];
    unique case (cls_i.op)
      OP_ADD:      s0_d.res = aw + bw;
      OP_SUB:      s0_d.res = aw - bw;
      OP_GT:       s0_d.cmp = !cls_i.lt && !cls_i.eq;
      OP_LT:       s0_d.cmp = cls_i.lt;
      OP_GE:       s0_d.cmp = !cls_i.lt;
      OP_LE:       s0_d.cmp = cls_i.lt || cls_i.eq;
      OP_EQ:       s0_d.cmp = cls_i.eq;
      OP_NE:       s0_d.cmp = !cls_i.eq;
      OP_MIN:      s0_d.res = cls_i.lt ? aw : bw;
      OP_MAX:      s0_d.res = (cls_i.lt || cls_i.eq) ? bw : aw;
      OP_INC:      s0_d.res = aw + 1'b1;
      OP_DEC:      s0_d.res = aw - 1'b1;
      OP_FROM_INT: s0_d.res = aw << F;
      OP_TO_INT:   s0_d.res = W'(tsum >>> F);
      default:     s0_d.res = '0;
    endcase
  end

  always_comb begin
    stg_d[0] = s0_d;
    for (int k = 1; k <= N; k++) begin
      stg_d[k] = stg_q[k-1];
      trial    = {stg_q[k-1].rem[W-1:0], stg_q[k-1].dvd[N-1]};
      if (trial >= {1'b0, stg_q[k-1].dvs}) begin
        stg_d[k].rem = trial - {1'b0, stg_q[k-1].dvs};
        stg_d[k].dvd = {stg_q[k-1].dvd[N-2:0], 1'b1};
      end else begin
        stg_d[k].rem = trial;
        stg_d[k].dvd = {stg_q[k-1].dvd[N-2:0], 1'b0};
      end
      if (k == 1 && stg_q[0].is_mul) begin
        stg_d[k].res = W'((stg_q[0].prod + (stg_q[0].prod[2*W-1] ? mbias : '0)) >> F);
      end
    end
  end

  assign vld_d = {vld_q[N-1:0], valid_i};
  assign q_w   = stg_q[N].dvd[W-1:0];

  always_comb begin
    logic [W-1:0] r;
    r = stg_q[N].res;
    if (stg_q[N].dz) begin
      r = {1'b0, {(W-1){1'b1}}};
    end else if (stg_q[N].is_div) begin
      r = stg_q[N].neg ? (~q_w) + 1'b1 : q_w;
    end
    out_d.result_value   = 32'(signed'(r));
    out_d.compare_true   = stg_q[N].cmp;
    out_d.divide_by_zero = stg_q[N].dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= N; k++) begin
        stg_q[k] <= stg_d[k];
      end
      out_q <= out_d;
    end
  end

endmodule

// File: tb/fixed_point_alu_top_tb.sv
// Self-checking testbench for the fixed-point ALU top level with random stimulus and stalls.
module fixed_point_alu_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpalu_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned LATENCY = DATA_WIDTH_DEF + FRAC_BITS_DEF + 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  out_t alu_results_q[$];
  int unsigned err_count = 0;
  int unsigned hold_cycles = 0;
  bit stim_done = 1'b0;

  fixed_point_alu_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_t alu_compute(in_t it);
    out_t r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] w;
    op_e cmd;
    a = 64'(it.operand_a);
    b = 64'(it.operand_b);
    w = '0;
    r = '0;
    cmd = op_e'(it.command);
    case (cmd)
      OP_ADD: w = a + b;
      OP_SUB: w = a - b;
      OP_MUL: w = (a * b) / (64'sd1 <<< FB);
      OP_DIV: begin
        if (b == 0) begin
          w = 64'sh7fffffff;
          r.divide_by_zero = 1'b1;
        end else begin
          w = (a * (64'sd1 <<< FB)) / b;
        end
      end
      OP_GT: r.compare_true = a > b;
      OP_LT: r.compare_true = a < b;
      OP_GE: r.compare_true = a >= b;
      OP_LE: r.compare_true = a <= b;
      OP_EQ: r.compare_true = a == b;
      OP_NE: r.compare_true = a != b;
      OP_MIN: w = (a < b) ? a : b;
      OP_MAX: w = (a > b) ? a : b;
      OP_INC: w = a + 1;
      OP_DEC: w = a - 1;
      OP_FROM_INT: w = a <<< FB;
      default: w = a / (64'sd1 <<< FB);
    endcase
    r.result_value = w[31:0];
    return r;
  endfunction

  task automatic send_beat(op_e cmd, logic [31:0] a, logic [31:0] b);
    int unsigned gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= '{command: cmd, operand_a: a, operand_b: b};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    alu_results_q.push_back(alu_compute('{command: cmd, operand_a: a, operand_b: b}));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom_range(0, 2048) - 1024;
      4: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< FB;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (alu_results_q.size() == 0) begin
        $error("result beat with no expectation: %h", out_data_o);
        err_count++;
      end else begin
        exp_r = alu_results_q.pop_front();
        if (out_data_o.result_value !== exp_r.result_value) begin
          $error("result_value expected %h actual %h",
                 exp_r.result_value, out_data_o.result_value);
          err_count++;
        end
        if (out_data_o.compare_true !== exp_r.compare_true) begin
          $error("compare_true expected %b actual %b",
                 exp_r.compare_true, out_data_o.compare_true);
          err_count++;
        end
        if (out_data_o.divide_by_zero !== exp_r.divide_by_zero) begin
          $error("divide_by_zero expected %b actual %b",
                 exp_r.divide_by_zero, out_data_o.divide_by_zero);
          err_count++;
        end
      end
    end
  end

  initial begin
    int unsigned wait_n;
    @(negedge clk_i);
    while (!stim_done) begin
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_n == 0) begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
    out_ready_i <= 1'b1;
  end

  task automatic test_extremes();
    logic [31:0] vals[4];
    vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    for (int c = 0; c < 16; c++) begin
      send_beat(op_e'(c), vals[c % 4], vals[(c + 1) % 4]);
    end
    send_beat(OP_DIV, 32'h0000_0100, 32'h0);
    send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_MIN, 32'h1234, 32'h1234);
    send_beat(OP_MAX, 32'hffff_0000, 32'hffff_0000);
    send_beat(OP_TO_INT, 32'hffff_ff01, 32'h0);
    send_beat(OP_MUL, 32'hffff_ff80, 32'h0000_0001);
    send_beat(OP_EQ, 32'h5, 32'h5);
  endtask

  task automatic test_backpressure();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    hold_cycles = 600;
    for (int i = 0; i < 60; i++) begin
      send_beat(op_e'($urandom_range(0, 15)), rand_operand(), rand_operand());
    end
  endtask

  task automatic test_random();
    logic [31:0] a;
    for (int i = 0; i < 1870; i++) begin
      a = rand_operand();
      send_beat(op_e'($urandom_range(0, 15)), a,
                ($urandom_range(0, 7) == 0) ? a : rand_operand());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
    while (alu_results_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("** fixed_point_alu_top: PASSED **");
    end else begin
      $display("** fixed_point_alu_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** fixed_point_alu_top: FAILED **");
    $finish;
  end
endmodule
